### sv/gsw_pkg.sv
// ----------------------------------------------------------------------------
// gsw_pkg
// Shared widths, tags, status codes and the result record of the grib1
// section walker.
// ----------------------------------------------------------------------------
package gsw_pkg;

   // width of every offset field on the result channel
   localparam int FIELD_W = 25;

   // default width of the internal byte position counter
   localparam int OFFSET_BITS_DEF = 25;

   // four-byte tags, as they sit in the shift register (first byte on top)
   localparam logic [31:0] TAG_GRIB = 32'h4752_4942;
   localparam logic [31:0] TAG_END  = 32'h3737_3737;

   // result status codes, first failing check wins
   typedef enum logic [3:0] {
      ST_OK         = 4'd0,
      ST_NO_MARKER  = 4'd1,
      ST_SHORT      = 4'd2,
      ST_NO_END     = 4'd3,
      ST_PDS        = 4'd4,
      ST_GDS        = 4'd5,
      ST_BMS_LONG   = 4'd6,
      ST_PREDEF_MAP = 4'd7,
      ST_BDS        = 4'd8,
      ST_NO_TRAILER = 4'd9
   } status_type;

   // one result beat
   typedef struct packed {
      status_type           status;
      logic [7:0]           edition;
      logic [FIELD_W-1:0]   marker_offset;
      logic [FIELD_W-1:0]   pds_offset;
      logic                 gds_present;
      logic [FIELD_W-1:0]   gds_offset;
      logic                 bms_present;
      logic [FIELD_W-1:0]   bms_offset;
      logic [FIELD_W-1:0]   bds_offset;
   } result_type;

endpackage

### sv/gsw_ifs.sv
// ----------------------------------------------------------------------------
// gsw channel interfaces
// Valid/ready channels for the byte stream in and the result beat out.
// ----------------------------------------------------------------------------
interface gsw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface gsw_rsp_if;
   import gsw_pkg::*;

   logic               valid;
   logic               ready;
   logic [3:0]         status;
   logic [7:0]         edition;
   logic [FIELD_W-1:0] marker_offset;
   logic [FIELD_W-1:0] pds_offset;
   logic               gds_present;
   logic [FIELD_W-1:0] gds_offset;
   logic               bms_present;
   logic [FIELD_W-1:0] bms_offset;
   logic [FIELD_W-1:0] bds_offset;

   modport source (output valid, status, edition, marker_offset, pds_offset,
                   gds_present, gds_offset, bms_present, bms_offset, bds_offset,
                   input ready);
   modport sink   (input valid, status, edition, marker_offset, pds_offset,
                   gds_present, gds_offset, bms_present, bms_offset, bds_offset,
                   output ready);
endinterface

### sv/grib1_section_walker.sv
// ----------------------------------------------------------------------------
// grib1_section_walker
// Walks the sections of one GRIB edition-1 product, one byte a beat, and
// gives one result beat after the product's last byte.
// ----------------------------------------------------------------------------
//  channel  | dir | fields                                  | beat
//  ---------+-----+-----------------------------------------+---------------
//  req_if   | in  | data_byte, last_byte                    | one per byte
//  rsp_if   | out | status, edition, marker/section offsets | one per product
//
//  one byte a cycle while req_if.ready is high; the parse state and the output register are the only
//  stages, so a result appears the cycle after its last byte is taken.
//  reset is synchronous and returns the walker to marker search.
//  req_if.ready drops only while a result waits and rsp_if.ready is low.
// ----------------------------------------------------------------------------
module grib1_section_walker #(
   parameter int OFFSET_BITS = gsw_pkg::OFFSET_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   gsw_req_if.sink   req_if,
   gsw_rsp_if.source rsp_if
);
   import gsw_pkg::*;

   logic       beat;
   logic       done;
   logic       take;
   result_type res;

   assign req_if.ready = take;
   assign beat         = req_if.valid && take;

   // parse state
   gsw_walker #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_walker (
      .clock       (clock),
      .reset       (reset),
      .beat_i      (beat),
      .data_byte_i (req_if.data_byte),
      .last_byte_i (req_if.last_byte),
      .done_o      (done),
      .res_o       (res)
   );

   // result output register
   gsw_rsp_reg u_rsp_reg (
      .clock  (clock),
      .reset  (reset),
      .load_i (done),
      .res_i  (res),
      .take_o (take),
      .rsp_if (rsp_if)
   );

endmodule

### sv/gsw_walker.sv
// ----------------------------------------------------------------------------
// gsw_walker
// Per-byte parse state: marker search, header capture, section walk and
// trailer check. Gives the finished result record on the last byte.
// ----------------------------------------------------------------------------
module gsw_walker #(
   parameter int OFFSET_BITS = gsw_pkg::OFFSET_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                beat_i,
   input  logic [7:0]          data_byte_i,
   input  logic                last_byte_i,
   output logic                done_o,
   output gsw_pkg::result_type res_o
);
   import gsw_pkg::*;

   typedef logic [OFFSET_BITS-1:0] pos_type;

   typedef enum logic [2:0] {
      PH_SEARCH, PH_HDR, PH_PDS, PH_GDS, PH_BMS, PH_BDS, PH_TAIL, PH_DONE
   } phase_type;

   localparam logic [7:0] FLAG_GDS = 8'h80;
   localparam logic [7:0] FLAG_BMS = 8'h40;

   // smallest legal length of each walked section
   function automatic logic [23:0] min_len(input phase_type ph);
      case (ph)
         PH_PDS:  min_len = 24'd8;
         PH_GDS:  min_len = 24'd3;
         PH_BMS:  min_len = 24'd6;
         PH_BDS:  min_len = 24'd3;
         default: min_len = 24'd0;
      endcase
   endfunction

   // failure code of each walked section
   function automatic status_type sec_code(input phase_type ph);
      case (ph)
         PH_PDS:  sec_code = ST_PDS;
         PH_GDS:  sec_code = ST_GDS;
         PH_BMS:  sec_code = ST_BMS_LONG;
         PH_BDS:  sec_code = ST_BDS;
         PH_TAIL: sec_code = ST_NO_TRAILER;
         default: sec_code = ST_OK;
      endcase
   endfunction

   // state registers
   logic [31:0] recent_ff,    recent_in;
   pos_type     pos_ff;
   phase_type   phase_ff,     phase_in;
   pos_type     marker_ff,    marker_in;
   logic [7:0]  edition_ff,   edition_in;
   logic [23:0] msg_len_ff,   msg_len_in;
   pos_type     sec_start_ff, sec_start_in;
   pos_type     next_bnd_ff,  next_bnd_in;
   logic [7:0]  flags_ff,     flags_in;
   pos_type     offs_ff [4];
   pos_type     offs_in [4];
   logic [1:0]  trailer_ff,   trailer_in;
   status_type  first_err_ff, first_err_in;
   logic [23:0] sec_len_ff,   sec_len_in;
   logic [15:0] map_ff,       map_in;

   // working values
   pos_type     hdr_rel;
   pos_type     sec_rel;
   pos_type     rel;
   pos_type     end_pos;
   phase_type   ph;
   phase_type   nxt;
   logic [23:0] len_base;
   logic        at_bnd;
   logic        stop;
   status_type  status;

   assign hdr_rel = pos_ff - marker_ff;
   assign sec_rel = pos_ff - sec_start_ff;
   assign end_pos = marker_ff + OFFSET_BITS'(msg_len_ff) - OFFSET_BITS'(1);
   assign at_bnd  = (phase_ff inside {PH_PDS, PH_GDS, PH_BMS, PH_BDS})
                    && (sec_rel >= OFFSET_BITS'(3)) && (pos_ff == next_bnd_ff);

   // section that follows the current one at its boundary
   always_comb begin
      case (phase_ff)
         PH_PDS: begin
            if ((flags_ff & FLAG_GDS) != '0) nxt = PH_GDS;
            else if ((flags_ff & FLAG_BMS) != '0) nxt = PH_BMS;
            else nxt = PH_BDS;
         end
         PH_GDS:  nxt = ((flags_ff & FLAG_BMS) != '0) ? PH_BMS : PH_BDS;
         PH_BMS:  nxt = PH_BDS;
         default: nxt = PH_TAIL;
      endcase
   end

   // next state for one byte
   always_comb begin
      recent_in    = {recent_ff[23:0], data_byte_i};
      phase_in     = phase_ff;
      marker_in    = marker_ff;
      edition_in   = edition_ff;
      msg_len_in   = msg_len_ff;
      sec_start_in = sec_start_ff;
      next_bnd_in  = next_bnd_ff;
      flags_in     = flags_ff;
      offs_in      = offs_ff;
      trailer_in   = trailer_ff;
      first_err_in = first_err_ff;
      sec_len_in   = sec_len_ff;
      map_in       = map_ff;
      ph           = phase_ff;
      rel          = sec_rel;
      len_base     = sec_len_ff;
      stop         = 1'b0;

      case (phase_ff)
         PH_SEARCH: begin
            if (recent_in == TAG_GRIB) begin
               marker_in = pos_ff - OFFSET_BITS'(3);
               phase_in  = PH_HDR;
            end
         end
         PH_HDR: begin
            if (hdr_rel < OFFSET_BITS'(7)) begin
               msg_len_in = {msg_len_ff[15:0], data_byte_i};
            end else begin
               edition_in = data_byte_i;
               phase_in   = PH_PDS;
               map_in     = '0;
               if (data_byte_i != '0) begin
                  // later editions: pds starts after the edition byte
                  if (msg_len_ff < 24'd8) trailer_in = 2'b01;
                  sec_start_in = pos_ff + OFFSET_BITS'(1);
                  sec_len_in   = '0;
                  offs_in[0]   = pos_ff + OFFSET_BITS'(1);
               end else begin
                  // edition 0: the length field is the pds length
                  sec_start_in = marker_ff + OFFSET_BITS'(4);
                  sec_len_in   = msg_len_ff;
                  offs_in[0]   = marker_ff + OFFSET_BITS'(4);
                  if (msg_len_ff < 24'd8) begin
                     first_err_in = ST_PDS;
                     phase_in     = PH_DONE;
                  end else begin
                     next_bnd_in = marker_ff + OFFSET_BITS'(4) + OFFSET_BITS'(msg_len_ff);
                  end
               end
            end
         end
         PH_PDS, PH_GDS, PH_BMS, PH_BDS, PH_TAIL: begin
            // section boundary: check the map word or step to the next section
            if (at_bnd) begin
               if ((phase_ff == PH_BMS) && (map_ff != '0)) begin
                  first_err_in = ST_PREDEF_MAP;
                  phase_in     = PH_DONE;
                  stop         = 1'b1;
               end else begin
                  ph           = nxt;
                  phase_in     = nxt;
                  sec_start_in = pos_ff;
                  rel          = '0;
                  len_base     = '0;
                  sec_len_in   = '0;
                  map_in       = '0;
                  case (nxt)
                     PH_GDS:  offs_in[1] = pos_ff;
                     PH_BMS:  offs_in[2] = pos_ff;
                     PH_BDS:  offs_in[3] = pos_ff;
                     default: ;
                  endcase
               end
            end
            if (!stop) begin
               if (ph == PH_TAIL) begin
                  if (rel == OFFSET_BITS'(3)) begin
                     phase_in = PH_DONE;
                     if (recent_in != TAG_END) first_err_in = ST_NO_TRAILER;
                  end
               end else if (rel < OFFSET_BITS'(3)) begin
                  // 3-byte big-endian section length
                  sec_len_in = {len_base[15:0], data_byte_i};
                  if (rel == OFFSET_BITS'(2)) begin
                     if (sec_len_in < min_len(ph)) begin
                        first_err_in = sec_code(ph);
                        phase_in     = PH_DONE;
                     end else begin
                        next_bnd_in = sec_start_ff + OFFSET_BITS'(sec_len_in);
                     end
                  end
               end else begin
                  if ((ph == PH_PDS) && (rel == OFFSET_BITS'(7))) flags_in = data_byte_i;
                  if ((ph == PH_BMS) && ((rel == OFFSET_BITS'(4)) || (rel == OFFSET_BITS'(5))))
                     map_in = {map_ff[7:0], data_byte_i};
               end
            end
         end
         default: ;
      endcase

      // message end: latch whether "7777" sits on the last framed byte
      if ((phase_in >= PH_PDS) && (edition_in != '0) && !trailer_ff[0]
          && (msg_len_ff >= 24'd8) && (pos_ff == end_pos))
         trailer_in = {recent_in == TAG_END, 1'b1};
   end

   // final status, earliest failing check first
   always_comb begin
      if (phase_in == PH_SEARCH)                            status = ST_NO_MARKER;
      else if (phase_in == PH_HDR)                          status = ST_SHORT;
      else if ((edition_in != '0) && !trailer_in[0])        status = ST_SHORT;
      else if ((edition_in != '0) && !trailer_in[1])        status = ST_NO_END;
      else if (first_err_in != ST_OK)                       status = first_err_in;
      else if (phase_in != PH_DONE)                         status = sec_code(phase_in);
      else                                                  status = ST_OK;
   end

   // result record, zero apart from the status on failure
   always_comb begin
      res_o        = '0;
      res_o.status = status;
      if (status == ST_OK) begin
         res_o.edition       = edition_in;
         res_o.marker_offset = FIELD_W'(marker_in);
         res_o.pds_offset    = FIELD_W'(offs_in[0]);
         res_o.gds_present   = (flags_in & FLAG_GDS) != '0;
         res_o.gds_offset    = res_o.gds_present ? FIELD_W'(offs_in[1]) : '0;
         res_o.bms_present   = (flags_in & FLAG_BMS) != '0;
         res_o.bms_offset    = res_o.bms_present ? FIELD_W'(offs_in[2]) : '0;
         res_o.bds_offset    = FIELD_W'(offs_in[3]);
      end
   end

   assign done_o = beat_i && last_byte_i;

   // state update; the last byte clears everything for the next product
   always_ff @(posedge clock) begin
      if (reset || done_o) begin
         recent_ff    <= '0;
         pos_ff       <= '0;
         phase_ff     <= PH_SEARCH;
         marker_ff    <= '0;
         edition_ff   <= '0;
         msg_len_ff   <= '0;
         sec_start_ff <= '0;
         next_bnd_ff  <= '0;
         flags_ff     <= '0;
         offs_ff      <= '{default: '0};
         trailer_ff   <= '0;
         first_err_ff <= ST_OK;
         sec_len_ff   <= '0;
         map_ff       <= '0;
      end else if (beat_i) begin
         recent_ff    <= recent_in;
         pos_ff       <= pos_ff + OFFSET_BITS'(1);
         phase_ff     <= phase_in;
         marker_ff    <= marker_in;
         edition_ff   <= edition_in;
         msg_len_ff   <= msg_len_in;
         sec_start_ff <= sec_start_in;
         next_bnd_ff  <= next_bnd_in;
         flags_ff     <= flags_in;
         offs_ff      <= offs_in;
         trailer_ff   <= trailer_in;
         first_err_ff <= first_err_in;
         sec_len_ff   <= sec_len_in;
         map_ff       <= map_in;
      end
   end

   // a product's last beat leaves the walker searching from position zero
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      done_o |=> (phase_ff == PH_SEARCH) && (pos_ff == '0))
      else $error("walker not cleared after last beat");

   // a recorded failure always stops the walk
   a_err_stops: assert property (@(posedge clock) disable iff (reset)
      (first_err_ff != ST_OK) |-> (phase_ff == PH_DONE))
      else $error("failure recorded while still walking");

   // position counts accepted beats inside a product
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      (beat_i && !last_byte_i) |=> (pos_ff == $past(pos_ff) + OFFSET_BITS'(1)))
      else $error("byte position did not advance");

endmodule

### sv/gsw_rsp_reg.sv
// ----------------------------------------------------------------------------
// gsw_rsp_reg
// Output register of the result channel; holds back the input side while a
// result waits and its consumer is not ready.
// ----------------------------------------------------------------------------
module gsw_rsp_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_i,
   input  gsw_pkg::result_type res_i,
   output logic                take_o,
   gsw_rsp_if.source           rsp_if
);
   import gsw_pkg::*;

   logic       valid_ff;
   result_type res_ff;

   // room for a new result when empty or draining this cycle
   assign take_o = !valid_ff || rsp_if.ready;

   // hold register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load_i) begin
         valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         valid_ff <= 1'b0;
      end
      if (load_i) begin
         res_ff <= res_i;
      end
   end

   // drive the channel
   assign rsp_if.valid         = valid_ff;
   assign rsp_if.status        = res_ff.status;
   assign rsp_if.edition       = res_ff.edition;
   assign rsp_if.marker_offset = res_ff.marker_offset;
   assign rsp_if.pds_offset    = res_ff.pds_offset;
   assign rsp_if.gds_present   = res_ff.gds_present;
   assign rsp_if.gds_offset    = res_ff.gds_offset;
   assign rsp_if.bms_present   = res_ff.bms_present;
   assign rsp_if.bms_offset    = res_ff.bms_offset;
   assign rsp_if.bds_offset    = res_ff.bds_offset;

   // a new result never lands on one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_i |-> (!valid_ff || rsp_if.ready))
      else $error("result overwritten before it was taken");

   // a loaded result is shown on the next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load_i |=> valid_ff && (res_ff == $past(res_i)))
      else $error("loaded result not presented");

   // failed products carry no offsets
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (res_ff.status != ST_OK)) |->
         (res_ff.edition == '0) && (res_ff.marker_offset == '0)
         && (res_ff.pds_offset == '0) && !res_ff.gds_present && !res_ff.bms_present
         && (res_ff.bds_offset == '0))
      else $error("failed result carries found fields");

endmodule
